### src/bpp_pkg.sv
`timescale 1ns / 1ps

package bpp_pkg;

    localparam int PAGE_BYTES = 8;

    typedef enum logic [2:0] {
        OP_POWER   = 3'd0,
        OP_TORQUE  = 3'd1,
        OP_FREQ    = 3'd2,
        OP_BALANCE = 3'd3,
        OP_EMIT    = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        SEL_STANDARD = 2'd0,
        SEL_WHEEL    = 2'd1,
        SEL_CRANK    = 2'd2,
        SEL_FREQ     = 2'd3
    } t_page_sel;

    localparam logic [7:0] PG_STANDARD  = 8'h10;
    localparam logic [7:0] PG_WHEEL     = 8'h11;
    localparam logic [7:0] PG_CRANK     = 8'h12;
    localparam logic [7:0] PG_FREQ      = 8'h20;
    localparam logic [7:0] INVALID_BYTE = 8'hFF;

    typedef struct packed {
        logic [7:0]  event_cnt;
        logic [7:0]  tick_cnt;
        logic [15:0] period_sum;
        logic [15:0] torque_sum;
    } t_torque_acc;

    typedef struct packed {
        logic [15:0] slope;
        logic [7:0]  power_event_cnt;
        logic [7:0]  pedal_balance;
        logic [7:0]  cadence_now;
        logic [15:0] power_sum;
        logic [15:0] power_now;
        t_torque_acc wheel;
        t_torque_acc crank;
        logic [7:0]  freq_event_cnt;
        logic [15:0] freq_time_sum;
        logic [15:0] freq_tick_sum;
    } t_acc_state;

    typedef logic [PAGE_BYTES-1:0][7:0] t_page;

endpackage

### src/bpp_accum.sv
`timescale 1ns / 1ps

module bpp_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_update,
    input  logic [2:0]        i_opcode,
    input  logic [15:0]       i_watts,
    input  logic [7:0]        i_cadence_in,
    input  logic              i_crank_side,
    input  logic [15:0]       i_period_delta,
    input  logic [15:0]       i_torque_delta,
    input  logic [15:0]       i_time_delta,
    input  logic [15:0]       i_tick_delta,
    input  logic [7:0]        i_balance_in,
    output bpp_pkg::t_acc_state o_state
);
    import bpp_pkg::*;

    t_acc_state  r_acc;
    t_acc_state  n_acc;
    t_torque_acc w_side;
    t_torque_acc w_side_next;

    assign w_side = i_crank_side ? r_acc.crank : r_acc.wheel;

    always_comb begin
        w_side_next            = w_side;
        w_side_next.event_cnt  = w_side.event_cnt + 8'd1;
        w_side_next.tick_cnt   = w_side.tick_cnt + 8'd1;
        w_side_next.period_sum = w_side.period_sum + i_period_delta;
        w_side_next.torque_sum = w_side.torque_sum + i_torque_delta;
    end

    always_comb begin
        n_acc = r_acc;
        if (i_cfg_we) begin
            n_acc.slope = i_cfg_wdata;
        end
        if (i_update) begin
            case (t_opcode'(i_opcode))
                OP_POWER: begin
                    n_acc.power_event_cnt = r_acc.power_event_cnt + 8'd1;
                    n_acc.power_sum       = r_acc.power_sum + i_watts;
                    n_acc.power_now       = i_watts;
                    n_acc.cadence_now     = i_cadence_in;
                end
                OP_TORQUE: begin
                    if (i_crank_side) begin
                        n_acc.crank = w_side_next;
                    end else begin
                        n_acc.wheel = w_side_next;
                    end
                end
                OP_FREQ: begin
                    n_acc.freq_event_cnt = r_acc.freq_event_cnt + 8'd1;
                    n_acc.freq_time_sum  = r_acc.freq_time_sum + i_time_delta;
                    n_acc.freq_tick_sum  = r_acc.freq_tick_sum + i_tick_delta;
                end
                OP_BALANCE: begin
                    n_acc.pedal_balance = i_balance_in;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc               <= '0;
            r_acc.pedal_balance <= INVALID_BYTE;
            r_acc.cadence_now   <= INVALID_BYTE;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_state = r_acc;

endmodule

### src/bpp_page_fmt.sv
`timescale 1ns / 1ps

module bpp_page_fmt (
    input  bpp_pkg::t_acc_state i_state,
    input  logic [1:0]          i_page_select,
    output bpp_pkg::t_page      o_page
);
    import bpp_pkg::*;

    t_torque_acc w_side;

    assign w_side = (t_page_sel'(i_page_select) == SEL_CRANK) ? i_state.crank : i_state.wheel;

    always_comb begin
        case (t_page_sel'(i_page_select))
            SEL_STANDARD: begin
                o_page[0] = PG_STANDARD;
                o_page[1] = i_state.power_event_cnt;
                o_page[2] = i_state.pedal_balance;
                o_page[3] = i_state.cadence_now;
                o_page[4] = i_state.power_sum[7:0];
                o_page[5] = i_state.power_sum[15:8];
                o_page[6] = i_state.power_now[7:0];
                o_page[7] = i_state.power_now[15:8];
            end
            SEL_WHEEL, SEL_CRANK: begin
                o_page[0] = (t_page_sel'(i_page_select) == SEL_CRANK) ? PG_CRANK : PG_WHEEL;
                o_page[1] = w_side.event_cnt;
                o_page[2] = w_side.tick_cnt;
                o_page[3] = i_state.cadence_now;
                o_page[4] = w_side.period_sum[7:0];
                o_page[5] = w_side.period_sum[15:8];
                o_page[6] = w_side.torque_sum[7:0];
                o_page[7] = w_side.torque_sum[15:8];
            end
            default: begin
                // The frequency page is sent most significant byte first.
                o_page[0] = PG_FREQ;
                o_page[1] = i_state.freq_event_cnt;
                o_page[2] = i_state.slope[15:8];
                o_page[3] = i_state.slope[7:0];
                o_page[4] = i_state.freq_time_sum[15:8];
                o_page[5] = i_state.freq_time_sum[7:0];
                o_page[6] = i_state.freq_tick_sum[15:8];
                o_page[7] = i_state.freq_tick_sum[7:0];
            end
        endcase
    end

endmodule

### src/bicycle_power_page_builder.sv
// An emit request shows its page on the output in the cycle after acceptance.
// Throughput: one request per cycle; every update is a single read-modify-write of
// the accumulator registers and the page is latched in one output register.
// The input stalls only while a finished page waits and the output is stalled.
// Reset is synchronous and active low: accumulators clear, balance and cadence read 0xFF.
`timescale 1ns / 1ps

module bicycle_power_page_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_watts,
    input  logic [7:0]  i_cadence_in,
    input  logic        i_crank_side,
    input  logic [15:0] i_period_delta,
    input  logic [15:0] i_torque_delta,
    input  logic [15:0] i_time_delta,
    input  logic [15:0] i_tick_delta,
    input  logic [7:0]  i_balance_in,
    input  logic [1:0]  i_page_select,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_page_byte_0,
    output logic [7:0]  o_page_byte_1,
    output logic [7:0]  o_page_byte_2,
    output logic [7:0]  o_page_byte_3,
    output logic [7:0]  o_page_byte_4,
    output logic [7:0]  o_page_byte_5,
    output logic [7:0]  o_page_byte_6,
    output logic [7:0]  o_page_byte_7
);
    import bpp_pkg::*;

    logic       w_accept;
    logic       w_emit;
    t_acc_state w_state;
    t_page      w_page;
    t_page      r_page;
    logic       r_out_valid;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_emit     = w_accept && (t_opcode'(i_opcode) == OP_EMIT);

    bpp_accum u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_update       (w_accept),
        .i_opcode       (i_opcode),
        .i_watts        (i_watts),
        .i_cadence_in   (i_cadence_in),
        .i_crank_side   (i_crank_side),
        .i_period_delta (i_period_delta),
        .i_torque_delta (i_torque_delta),
        .i_time_delta   (i_time_delta),
        .i_tick_delta   (i_tick_delta),
        .i_balance_in   (i_balance_in),
        .o_state        (w_state)
    );

    // The page is built from the state as it stands before this request.
    bpp_page_fmt u_page_fmt (
        .i_state       (w_state),
        .i_page_select (i_page_select),
        .o_page        (w_page)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_page <= w_page;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_page_byte_0 = r_page[0];
    assign o_page_byte_1 = r_page[1];
    assign o_page_byte_2 = r_page[2];
    assign o_page_byte_3 = r_page[3];
    assign o_page_byte_4 = r_page[4];
    assign o_page_byte_5 = r_page[5];
    assign o_page_byte_6 = r_page[6];
    assign o_page_byte_7 = r_page[7];

endmodule

### src/bpp_checker.sv
`timescale 1ns / 1ps

module bpp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [2:0] i_opcode,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_page_byte_0,
    input logic [7:0] o_page_byte_7
);
    import bpp_pkg::*;

    // A page waiting on a stalled output stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("page withdrawn while stalled");

    a_page_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_page_byte_0) && $stable(o_page_byte_7))
        else $error("stalled page changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("page offered after reset");

    // Every accepted emit request yields a page with a known page number.
    a_emit_gives_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_opcode == OP_EMIT |=>
            o_out_valid && (o_page_byte_0 == PG_STANDARD || o_page_byte_0 == PG_WHEEL ||
                            o_page_byte_0 == PG_CRANK || o_page_byte_0 == PG_FREQ))
        else $error("emit request gave no valid page");

    // Requests other than emit must never produce a page of their own.
    a_no_spurious_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_opcode != OP_EMIT && !(o_out_valid && i_out_stall)
            |=> !o_out_valid)
        else $error("page produced without an emit request");

endmodule

bind bicycle_power_page_builder bpp_checker u_bpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_opcode      (i_opcode),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_page_byte_0 (o_page_byte_0),
    .o_page_byte_7 (o_page_byte_7)
);

### tb/sv/tb_bicycle_power_page_builder.sv
`timescale 1ns / 1ps

module tb_bicycle_power_page_builder;
    import bpp_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int WRAP_EVENTS  = 256;

    localparam logic [2:0] OP_UNUSED_MIN = 3'd5;
    localparam logic [2:0] OP_UNUSED_MAX = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] watts;
        logic [7:0]  cadence;
        logic        crank_side;
        logic [15:0] period_delta;
        logic [15:0] torque_delta;
        logic [15:0] time_delta;
        logic [15:0] tick_delta;
        logic [7:0]  balance;
        logic [1:0]  page_select;
    } t_request;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_SPOTTY,
        DRAIN_CHOKED
    } t_drain_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_opcode;
    logic [15:0] i_watts;
    logic [7:0]  i_cadence_in;
    logic        i_crank_side;
    logic [15:0] i_period_delta;
    logic [15:0] i_torque_delta;
    logic [15:0] i_time_delta;
    logic [15:0] i_tick_delta;
    logic [7:0]  i_balance_in;
    logic [1:0]  i_page_select;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_page_byte_0;
    logic [7:0]  o_page_byte_1;
    logic [7:0]  o_page_byte_2;
    logic [7:0]  o_page_byte_3;
    logic [7:0]  o_page_byte_4;
    logic [7:0]  o_page_byte_5;
    logic [7:0]  o_page_byte_6;
    logic [7:0]  o_page_byte_7;

    bicycle_power_page_builder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_watts        (i_watts),
        .i_cadence_in   (i_cadence_in),
        .i_crank_side   (i_crank_side),
        .i_period_delta (i_period_delta),
        .i_torque_delta (i_torque_delta),
        .i_time_delta   (i_time_delta),
        .i_tick_delta   (i_tick_delta),
        .i_balance_in   (i_balance_in),
        .i_page_select  (i_page_select),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_page_byte_0  (o_page_byte_0),
        .o_page_byte_1  (o_page_byte_1),
        .o_page_byte_2  (o_page_byte_2),
        .o_page_byte_3  (o_page_byte_3),
        .o_page_byte_4  (o_page_byte_4),
        .o_page_byte_5  (o_page_byte_5),
        .o_page_byte_6  (o_page_byte_6),
        .o_page_byte_7  (o_page_byte_7)
    );

    t_acc_state sensor_acc;
    t_page      pending_pages[$];
    int         mismatches;
    int         burst_left;
    bit         sender_pacing;
    int         idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void clear_accumulators();
        sensor_acc               = '0;
        sensor_acc.pedal_balance = INVALID_BYTE;
        sensor_acc.cadence_now   = INVALID_BYTE;
    endfunction

    function automatic t_page format_page(input logic [1:0] sel);
        t_page       pg;
        t_torque_acc acc;
        case (t_page_sel'(sel))
            SEL_STANDARD: begin
                pg[0] = PG_STANDARD;
                pg[1] = sensor_acc.power_event_cnt;
                pg[2] = sensor_acc.pedal_balance;
                pg[3] = sensor_acc.cadence_now;
                pg[4] = sensor_acc.power_sum[7:0];
                pg[5] = sensor_acc.power_sum[15:8];
                pg[6] = sensor_acc.power_now[7:0];
                pg[7] = sensor_acc.power_now[15:8];
            end
            SEL_WHEEL, SEL_CRANK: begin
                acc   = (sel == SEL_CRANK) ? sensor_acc.crank : sensor_acc.wheel;
                pg[0] = (sel == SEL_CRANK) ? PG_CRANK : PG_WHEEL;
                pg[1] = acc.event_cnt;
                pg[2] = acc.tick_cnt;
                pg[3] = sensor_acc.cadence_now;
                pg[4] = acc.period_sum[7:0];
                pg[5] = acc.period_sum[15:8];
                pg[6] = acc.torque_sum[7:0];
                pg[7] = acc.torque_sum[15:8];
            end
            default: begin
                // The torque frequency page carries its words most significant byte first.
                pg[0] = PG_FREQ;
                pg[1] = sensor_acc.freq_event_cnt;
                pg[2] = sensor_acc.slope[15:8];
                pg[3] = sensor_acc.slope[7:0];
                pg[4] = sensor_acc.freq_time_sum[15:8];
                pg[5] = sensor_acc.freq_time_sum[7:0];
                pg[6] = sensor_acc.freq_tick_sum[15:8];
                pg[7] = sensor_acc.freq_tick_sum[7:0];
            end
        endcase
        return pg;
    endfunction

    function automatic void accumulate(input t_request req);
        t_torque_acc acc;
        case (req.opcode)
            OP_POWER: begin
                sensor_acc.power_event_cnt = sensor_acc.power_event_cnt + 8'd1;
                sensor_acc.power_sum       = sensor_acc.power_sum + req.watts;
                sensor_acc.power_now       = req.watts;
                sensor_acc.cadence_now     = req.cadence;
            end
            OP_TORQUE: begin
                acc            = req.crank_side ? sensor_acc.crank : sensor_acc.wheel;
                acc.event_cnt  = acc.event_cnt + 8'd1;
                acc.tick_cnt   = acc.tick_cnt + 8'd1;
                acc.period_sum = acc.period_sum + req.period_delta;
                acc.torque_sum = acc.torque_sum + req.torque_delta;
                if (req.crank_side) begin
                    sensor_acc.crank = acc;
                end else begin
                    sensor_acc.wheel = acc;
                end
            end
            OP_FREQ: begin
                sensor_acc.freq_event_cnt = sensor_acc.freq_event_cnt + 8'd1;
                sensor_acc.freq_time_sum  = sensor_acc.freq_time_sum + req.time_delta;
                sensor_acc.freq_tick_sum  = sensor_acc.freq_tick_sum + req.tick_delta;
            end
            OP_BALANCE: begin
                sensor_acc.pedal_balance = req.balance;
            end
            OP_EMIT: begin
                pending_pages.push_back(format_page(req.page_select));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_request make_request(input logic [2:0] op);
        t_request req;
        req.opcode       = op;
        req.watts        = 16'($urandom);
        req.cadence      = 8'($urandom);
        req.crank_side   = 1'($urandom);
        req.period_delta = 16'($urandom);
        req.torque_delta = 16'($urandom);
        req.time_delta   = 16'($urandom);
        req.tick_delta   = 16'($urandom);
        req.balance      = 8'($urandom);
        req.page_select  = 2'($urandom);
        return req;
    endfunction

    function automatic logic [2:0] pick_opcode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 18) return OP_POWER;
        if (roll < 38) return OP_TORQUE;
        if (roll < 54) return OP_FREQ;
        if (roll < 62) return OP_BALANCE;
        if (roll < 93) return OP_EMIT;
        return 3'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
    endfunction

    // Must be entered on a clock edge; the request is folded into the
    // accumulators at the edge that accepts it.
    task automatic send_request(input t_request req);
        int gap;
        if (burst_left == 0) begin
            gap        = sender_pacing ? $urandom_range(1, 6) : 0;
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_opcode       <= req.opcode;
        i_watts        <= req.watts;
        i_cadence_in   <= req.cadence;
        i_crank_side   <= req.crank_side;
        i_period_delta <= req.period_delta;
        i_torque_delta <= req.torque_delta;
        i_time_delta   <= req.time_delta;
        i_tick_delta   <= req.tick_delta;
        i_balance_in   <= req.balance;
        i_page_select  <= req.page_select;
        do @(posedge i_clk); while (o_in_stall);
        accumulate(req);
    endtask

    task automatic send_emit(input t_page_sel sel);
        t_request req;
        req             = make_request(OP_EMIT);
        req.page_select = sel;
        send_request(req);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_pages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slope(input logic [15:0] slope);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= slope;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        sensor_acc.slope = slope;
    endtask

    task automatic test_reset_values();
        sender_pacing = 1'b0;
        send_emit(SEL_STANDARD);
        send_emit(SEL_WHEEL);
        send_emit(SEL_CRANK);
        send_emit(SEL_FREQ);
    endtask

    task automatic test_field_extremes();
        t_request req;
        req         = make_request(OP_POWER);
        req.watts   = 16'hFFFF;
        req.cadence = 8'h00;
        send_request(req);
        // A second full-scale reading makes the power sum wrap.
        req         = make_request(OP_POWER);
        req.watts   = 16'hFFFF;
        req.cadence = 8'hFF;
        send_request(req);
        req              = make_request(OP_TORQUE);
        req.crank_side   = 1'b0;
        req.period_delta = 16'hFFFF;
        req.torque_delta = 16'h0000;
        send_request(req);
        req              = make_request(OP_TORQUE);
        req.crank_side   = 1'b1;
        req.period_delta = 16'h0000;
        req.torque_delta = 16'hFFFF;
        send_request(req);
        req              = make_request(OP_TORQUE);
        req.crank_side   = 1'b1;
        req.period_delta = 16'hFFFF;
        req.torque_delta = 16'hFFFF;
        send_request(req);
        req            = make_request(OP_FREQ);
        req.time_delta = 16'hFFFF;
        req.tick_delta = 16'h0001;
        send_request(req);
        req            = make_request(OP_FREQ);
        req.time_delta = 16'h0001;
        req.tick_delta = 16'hFFFF;
        send_request(req);
        req         = make_request(OP_BALANCE);
        req.balance = 8'h00;
        send_request(req);
        send_emit(SEL_STANDARD);
        send_emit(SEL_WHEEL);
        send_emit(SEL_CRANK);
        send_emit(SEL_FREQ);
        // Unused opcodes with every field high must leave the state alone.
        for (int op = OP_UNUSED_MIN; op <= OP_UNUSED_MAX; op++) begin
            req        = '1;
            req.opcode = 3'(op);
            send_request(req);
        end
        send_emit(SEL_STANDARD);
        send_emit(SEL_CRANK);
    endtask

    task automatic test_slope_extremes();
        write_slope(16'hFFFF);
        send_emit(SEL_FREQ);
        write_slope(16'h0000);
        send_emit(SEL_FREQ);
    endtask

    // One event counter, picked at random, is driven right round its range.
    task automatic test_count_wrap();
        t_request  req;
        t_page_sel sel;
        sender_pacing = 1'b1;
        sel = t_page_sel'($urandom_range(0, 3));
        for (int n = 0; n < WRAP_EVENTS; n++) begin
            if (n % 64 == 0) begin
                send_emit(sel);
            end
            case (sel)
                SEL_STANDARD: req = make_request(OP_POWER);
                SEL_WHEEL: begin
                    req            = make_request(OP_TORQUE);
                    req.crank_side = 1'b0;
                end
                SEL_CRANK: begin
                    req            = make_request(OP_TORQUE);
                    req.crank_side = 1'b1;
                end
                default: req = make_request(OP_FREQ);
            endcase
            send_request(req);
        end
        send_emit(sel);
    endtask

    task automatic test_random_traffic();
        logic [15:0] slope;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       slope = 16'hFFFF;
                1:       slope = 16'h0000;
                default: slope = 16'($urandom);
            endcase
            write_slope(slope);
            // Every other phase runs the sender flat out.
            sender_pacing = (phase % 2 == 0);
            repeat (15) send_request(make_request(pick_opcode()));
        end
    endtask

    initial begin : out_stall_pattern
        t_drain_mode mode;
        int          span;
        i_out_stall <= 1'b0;
        forever begin
            mode = t_drain_mode'($urandom_range(DRAIN_FREE, DRAIN_CHOKED));
            span = $urandom_range(20, 80);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    DRAIN_FREE:   i_out_stall <= 1'b0;
                    DRAIN_SPOTTY: i_out_stall <= ($urandom_range(0, 2) == 0);
                    default:      i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : page_check
        t_page got;
        t_page want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_page_byte_7, o_page_byte_6, o_page_byte_5, o_page_byte_4,
                   o_page_byte_3, o_page_byte_2, o_page_byte_1, o_page_byte_0};
            if (pending_pages.size() == 0) begin
                $display("%0t: page with no emit request pending: expected none, actual %h",
                         $time, got);
                mismatches++;
            end else begin
                want = pending_pages.pop_front();
                for (int b = 0; b < PAGE_BYTES; b++) begin
                    if (got[b] !== want[b]) begin
                        $display("%0t: page byte %0d expected %02h actual %02h",
                                 $time, b, want[b], got[b]);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        mismatches    = 0;
        burst_left    = 0;
        sender_pacing = 1'b0;
        clear_accumulators();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_opcode       <= OP_POWER;
        i_watts        <= '0;
        i_cadence_in   <= '0;
        i_crank_side   <= 1'b0;
        i_period_delta <= '0;
        i_torque_delta <= '0;
        i_time_delta   <= '0;
        i_tick_delta   <= '0;
        i_balance_in   <= '0;
        i_page_select  <= SEL_STANDARD;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_field_extremes();
        test_slope_extremes();
        test_count_wrap();
        test_random_traffic();
        wait_drained();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
src/bpp_pkg.sv
src/bpp_accum.sv
src/bpp_page_fmt.sv
src/bicycle_power_page_builder.sv
src/bpp_checker.sv
tb/sv/tb_bicycle_power_page_builder.sv
